// File: src/wed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_pkg
// Shared widths, constants and types for the weighted Euclidean distance block.
// ----------------------------------------------------------------------------
package wed_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int MAG_W      = SAMPLE_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_BITS  = 8;
  localparam int TERM_W     = SQ_W + WEIGHT_W;
  localparam int SUM_W      = 62;
  localparam int ROOT_IN_W  = SUM_W - FRAC_BITS;
  localparam int DIST_W     = 27;
  localparam int REM_W      = DIST_W + 1;
  localparam int ITER_W     = $clog2(DIST_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = WEIGHT_W'(1 << FRAC_BITS);
  localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

  typedef struct packed {
    logic [ROOT_IN_W-1:0] sum;
    logic                 sat;
  } sum_item_t;

endpackage

// File: src/wed_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_if
// Request channels: element pairs in, distances out, register writes.
// ----------------------------------------------------------------------------
interface wed_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [wed_pkg::SAMPLE_W-1:0]      a_elem;
  logic signed [wed_pkg::SAMPLE_W-1:0]      b_elem;
  logic        [wed_pkg::WEIGHT_W-1:0]      weight;
  logic                                     last;
  modport source (output valid, a_elem, b_elem, weight, last, input ready);
  modport sink   (input valid, a_elem, b_elem, weight, last, output ready);
endinterface

interface wed_out_if;
  logic                          valid;
  logic                          ready;
  logic [wed_pkg::DIST_W-1:0]    distance;
  logic                          saturated;
  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

interface wed_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: src/weighted_euclidean_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_euclidean_distance
// Streams element pairs, accumulates weighted squared differences and gives
// the integer square root of the sum on each vector's last pair.
//
//   channel  dir  payload                               request moves
//   in_ch    in   a_elem, b_elem, weight, last          one element pair
//   out_ch   out  distance, saturated                   one distance
//   cfg_ch   in   data (use_weights)                    one register write
//
// Element pairs are taken into a three-stage multiply-accumulate pipeline,
// one per cycle while in_ch.ready is high. The root unit resolves one result
// bit per cycle: per vector it loads the sum, resolves the 27 result bits and
// holds the result until out_ch takes it. Finished sums wait in a two-entry
// queue.
// Synchronous reset clears the sum, the flag, the register and all valids.
// in_ch.ready drops only while a last pair waits at the accumulator on a full
// queue; out_ch stalls hold the result and the root unit.
// ----------------------------------------------------------------------------
module weighted_euclidean_distance (
  input  logic        clk,
  input  logic        rst_n,
  wed_in_if.sink      in_ch,
  wed_out_if.source   out_ch,
  wed_cfg_if.sink     cfg_ch
);

  wed_pkg::sum_item_t push_data;
  wed_pkg::sum_item_t pop_data;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  wed_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_data (push_data),
    .q_push (push),
    .q_full (q_full)
  );

  wed_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .full    (q_full),
    .pop     (pop),
    .rd_data (pop_data),
    .empty   (q_empty)
  );

  wed_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (pop_data),
    .q_valid (!q_empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: src/wed_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_front
// Multiply-accumulate pipeline: difference, square, weight, saturating sum.
// ----------------------------------------------------------------------------
module wed_front (
  input  logic                clk,
  input  logic                rst_n,
  wed_in_if.sink              in_ch,
  wed_cfg_if.sink             cfg_ch,
  output wed_pkg::sum_item_t  q_data,
  output logic                q_push,
  input  logic                q_full
);

  logic                              use_weights_r;
  logic                              v0_r, v1_r, v2_r;
  logic                              last0_r, last1_r, last2_r;
  logic [wed_pkg::MAG_W-1:0]         mag_r;
  logic [wed_pkg::WEIGHT_W-1:0]      w0_r, w1_r;
  logic [wed_pkg::SQ_W-1:0]          sq_r;
  logic [wed_pkg::TERM_W-1:0]        term_r;
  logic [wed_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic                              sat_r, sat_nxt;

  logic                              en;
  logic signed [wed_pkg::DIFF_W-1:0] diff;
  logic signed [wed_pkg::DIFF_W-1:0] diff_abs;
  logic [wed_pkg::SUM_W:0]           sum_add;

  assign en            = !(v2_r && last2_r && q_full);
  assign in_ch.ready   = en;
  assign cfg_ch.ready  = 1'b1;

  assign diff     = {in_ch.a_elem[wed_pkg::SAMPLE_W-1], in_ch.a_elem}
                  - {in_ch.b_elem[wed_pkg::SAMPLE_W-1], in_ch.b_elem};
  assign diff_abs = diff[wed_pkg::DIFF_W-1] ? -diff : diff;

  assign sum_add = {1'b0, sum_r} + {{(wed_pkg::SUM_W + 1 - wed_pkg::TERM_W){1'b0}}, term_r};

  always_comb begin
    if (sum_add[wed_pkg::SUM_W]) begin
      sum_nxt = wed_pkg::SUM_MAX;
      sat_nxt = 1'b1;
    end else begin
      sum_nxt = sum_add[wed_pkg::SUM_W-1:0];
      sat_nxt = sat_r;
    end
  end

  assign q_push      = v2_r && last2_r && !q_full;
  assign q_data.sum  = sum_nxt[wed_pkg::SUM_W-1:wed_pkg::FRAC_BITS];
  assign q_data.sat  = sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_weights_r <= 1'b0;
      v0_r          <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      sum_r         <= '0;
      sat_r         <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        use_weights_r <= cfg_ch.data;
      end
      if (en) begin
        v0_r <= in_ch.valid;
        v1_r <= v0_r;
        v2_r <= v1_r;
        if (v2_r) begin
          if (last2_r) begin
            sum_r <= '0;
            sat_r <= 1'b0;
          end else begin
            sum_r <= sum_nxt;
            sat_r <= sat_nxt;
          end
        end
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= diff_abs[wed_pkg::MAG_W-1:0];
      w0_r    <= use_weights_r ? in_ch.weight : wed_pkg::ONE_WEIGHT;
      last0_r <= in_ch.last;
      sq_r    <= mag_r * mag_r;
      w1_r    <= w0_r;
      last1_r <= last0_r;
      term_r  <= sq_r * w1_r;
      last2_r <= last1_r;
    end
  end

endmodule

// File: src/wed_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_fifo
// Short queue of finished sums between the accumulator and the root unit.
// ----------------------------------------------------------------------------
module wed_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wed_pkg::sum_item_t  wr_data,
  output logic                full,
  input  logic                pop,
  output wed_pkg::sum_item_t  rd_data,
  output logic                empty
);

  wed_pkg::sum_item_t               mem_r [wed_pkg::QUEUE_DEPTH];
  logic [wed_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [wed_pkg::QCNT_W-1:0]       cnt_r;

  assign full    = (cnt_r == wed_pkg::QCNT_W'(wed_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == wed_pkg::QPTR_W'(wed_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == wed_pkg::QPTR_W'(wed_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

// File: src/wed_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_back
// Digit-by-digit integer square root, one result bit per cycle, and the
// output register.
// ----------------------------------------------------------------------------
module wed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wed_pkg::sum_item_t  q_data,
  input  logic                q_valid,
  output logic                q_pop,
  wed_out_if.source           out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t                          state_r;
  logic [wed_pkg::ROOT_IN_W-1:0]   x_r;
  logic [wed_pkg::REM_W-1:0]       rem_r;
  logic [wed_pkg::DIST_W-1:0]      root_r;
  logic [wed_pkg::ITER_W-1:0]      cnt_r;
  logic                            sat_r;
  logic                            out_valid_r;

  logic [wed_pkg::REM_W+1:0]       rem_sh;
  logic [wed_pkg::REM_W+1:0]       trial;
  logic [wed_pkg::REM_W+1:0]       rem_diff;
  logic                            take;

  assign rem_sh   = {rem_r, x_r[wed_pkg::ROOT_IN_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign take     = (rem_sh >= trial);

  assign q_pop            = (state_r == ST_IDLE) && q_valid;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = root_r;
  assign out_ch.saturated = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            x_r     <= q_data.sum;
            sat_r   <= q_data.sat;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          x_r <= {x_r[wed_pkg::ROOT_IN_W-3:0], 2'b00};
          if (take) begin
            rem_r  <= rem_diff[wed_pkg::REM_W-1:0];
            root_r <= {root_r[wed_pkg::DIST_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[wed_pkg::REM_W-1:0];
            root_r <= {root_r[wed_pkg::DIST_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == wed_pkg::ITER_W'(wed_pkg::DIST_W - 1)) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_weighted_euclidean_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_euclidean_distance
// Streams element pairs through the distance block: a table of directed
// vectors (extremes, weight of zero, fractional weights, both register
// settings), then random vectors under three idling regimes and a long
// output hold-off. Each distance is checked field by field against the
// table's value, else a running-sum predictor fed every accepted request.
// ----------------------------------------------------------------------------
module tb_weighted_euclidean_distance;

  localparam int          SETTLE_CYCLES = 48;
  localparam int          PHASE_ITEMS   = 420;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [63:0] SUM_CAP       = 64'(wed_pkg::SUM_MAX);

  typedef enum logic [0:0] {ROW_PAIR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                           kind;
    logic                                cfg_val;
    logic signed [wed_pkg::SAMPLE_W-1:0] a;
    logic signed [wed_pkg::SAMPLE_W-1:0] b;
    logic [wed_pkg::WEIGHT_W-1:0]        w;
    logic                                last;
    int unsigned                         reps;
    logic                                known;
    logic [wed_pkg::DIST_W-1:0]          exp_dist;
    logic                                sat;
  } vec_row_t;

  typedef struct packed {
    logic [wed_pkg::DIST_W-1:0] distance;
    logic                       saturated;
  } dist_res_t;

  localparam vec_row_t DIRECTED [0:17] = '{
    '{ROW_PAIR, 1'b0, 16'sd3, -16'sd1, 16'h0000, 1'b1, 1, 1'b1, 27'd4, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 1, 1'b1, 27'd65535, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sh8000, 16'sh7FFF, 16'h0000, 1'b1, 1, 1'b1, 27'd65535, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sh8000, 16'sh8000, 16'h1234, 1'b1, 1, 1'b1, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd100, 16'sd50, 16'h1234, 1'b0, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, -16'sd7, 16'sd9, 16'h0000, 1'b0, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd1234, -16'sd4321, 16'h0000, 1'b1, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd5, 16'sd2, 16'h0000, 1'b1, 3, 1'b0, 27'd0, 1'b0},
    '{ROW_CFG,  1'b1, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd10, 16'sd0, 16'h0100, 1'b1, 1, 1'b1, 27'd10, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd1000, -16'sd1000, 16'h0000, 1'b1, 1, 1'b1, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd2, 16'sd0, 16'h0001, 1'b0, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd16, 16'sd0, 16'h0080, 1'b0, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, -16'sd300, 16'sd0, 16'h0000, 1'b1, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, 16'sd3, 16'sd0, 16'h0100, 1'b1, 1, 1'b1, 27'd3, 1'b0},
    '{ROW_CFG,  1'b0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1, 1'b0, 27'd0, 1'b0},
    '{ROW_PAIR, 1'b0, -16'sd1, 16'sd1, 16'hFFFF, 1'b1, 1, 1'b1, 27'd2, 1'b0}
  };

  logic clk;
  logic rst_n;

  wed_in_if  in_ch ();
  wed_out_if out_ch ();
  wed_cfg_if cfg_ch ();

  weighted_euclidean_distance u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [63:0] acc_sum    = '0;
  logic        acc_sat    = 1'b0;
  logic        weights_on = 1'b0;

  dist_res_t pending_dist [$];
  dist_res_t want;
  int        mismatch_count = 0;
  int        in_gap_pct     = 0;
  int        out_stall_pct  = 0;
  int        hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_v, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [wed_pkg::DIST_W-1:0] floor_sqrt(input logic [63:0] x);
    logic [wed_pkg::DIST_W-1:0] root;
    logic [63:0]                trial;
    root = '0;
    for (int i = wed_pkg::DIST_W - 1; i >= 0; i--) begin
      trial = 64'(root | (wed_pkg::DIST_W'(1) << i));
      if (trial * trial <= x) root = wed_pkg::DIST_W'(trial);
    end
    return root;
  endfunction

  // add one pair to the running sum; on last, return the distance and clear
  function automatic bit accumulate_pair(input logic signed [wed_pkg::SAMPLE_W-1:0] a,
                                         input logic signed [wed_pkg::SAMPLE_W-1:0] b,
                                         input logic [wed_pkg::WEIGHT_W-1:0] w_in,
                                         input logic last,
                                         output dist_res_t res);
    logic signed [wed_pkg::DIFF_W-1:0] d;
    logic [wed_pkg::MAG_W-1:0]         mag;
    logic [63:0]                       sq;
    logic [63:0]                       w;
    logic [63:0]                       term;
    d   = wed_pkg::DIFF_W'(a) - wed_pkg::DIFF_W'(b);
    mag = d[wed_pkg::DIFF_W-1] ? wed_pkg::MAG_W'(-d) : wed_pkg::MAG_W'(d);
    sq  = 64'(mag) * 64'(mag);
    w   = weights_on ? 64'(w_in) : 64'(wed_pkg::ONE_WEIGHT);
    res = '0;
    if (w != 0 && sq != 0) begin
      if (sq > SUM_CAP / w) begin
        acc_sum = SUM_CAP;
        acc_sat = 1'b1;
      end else begin
        term = sq * w;
        if (term > SUM_CAP - acc_sum) begin
          acc_sum = SUM_CAP;
          acc_sat = 1'b1;
        end else begin
          acc_sum = acc_sum + term;
        end
      end
    end
    if (!last) return 1'b0;
    res.distance  = floor_sqrt(acc_sum >> wed_pkg::FRAC_BITS);
    res.saturated = acc_sat;
    acc_sum = '0;
    acc_sat = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_pair(input logic signed [wed_pkg::SAMPLE_W-1:0] a,
                           input logic signed [wed_pkg::SAMPLE_W-1:0] b,
                           input logic [wed_pkg::WEIGHT_W-1:0] w,
                           input logic last,
                           input logic known,
                           input logic [wed_pkg::DIST_W-1:0] exp_dist,
                           input logic sat);
    dist_res_t res;
    if ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.a_elem <= a;
    in_ch.b_elem <= b;
    in_ch.weight <= w;
    in_ch.last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (accumulate_pair(a, b, w, last, res)) begin
      if (known) begin
        res.distance  = exp_dist;
        res.saturated = sat;
      end
      pending_dist.push_back(res);
    end
  endtask

  task automatic settle_and_configure(input logic on);
    in_ch.valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= on;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    weights_on = on;
  endtask

  function automatic logic signed [wed_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return wed_pkg::SAMPLE_W'($urandom_range(0, 31)) - 16'sd16;
      default: return wed_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [wed_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return wed_pkg::ONE_WEIGHT;
      3: return wed_pkg::WEIGHT_W'($urandom_range(1, 15));
      default: return wed_pkg::WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic random_vectors(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60)      len = $urandom_range(1, 4);
      else if (pick < 90) len = $urandom_range(5, 16);
      else                len = $urandom_range(17, 64);
      for (int k = 0; k < len; k++)
        send_pair(rand_sample(), rand_sample(), rand_weight(), k == len - 1, 1'b0, '0, 1'b0);
      sent += len;
    end
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dist.size() == 0) begin
        report_mismatch("unexpected distance", out_ch.distance, -1);
      end else begin
        want = pending_dist.pop_front();
        if (out_ch.distance !== want.distance)
          report_mismatch("distance", out_ch.distance, want.distance);
        if (out_ch.saturated !== want.saturated)
          report_mismatch("saturated", out_ch.saturated, want.saturated);
      end
    end
  end

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.a_elem <= '0;
    in_ch.b_elem <= '0;
    in_ch.weight <= '0;
    in_ch.last   <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 1'b0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_pct    = 27;
    out_stall_pct = 47;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle_and_configure(DIRECTED[i].cfg_val);
      end else begin
        for (int unsigned r = 1; r <= DIRECTED[i].reps; r++)
          send_pair(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].w,
                    DIRECTED[i].last && r == DIRECTED[i].reps,
                    DIRECTED[i].known && r == DIRECTED[i].reps,
                    DIRECTED[i].exp_dist, DIRECTED[i].sat);
      end
    end

    for (int p = 0; p < 3; p++) begin
      settle_and_configure(p != 1);
      in_gap_pct    = (p == 0) ? 27 : (p == 1) ? 47 : 0;
      out_stall_pct = (p == 0) ? 47 : (p == 1) ? 27 : 0;
      // hold the output so the queue fills and the input stalls
      if (p == 2) hold_left = HOLD_CYCLES;
      random_vectors(PHASE_ITEMS);
    end

    in_ch.valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
